FILE: rtl/core/ffea_pkg.sv
// ----------------------------------------------------------------------------
// ffea_pkg
// shared types and constants of the first-fit extent allocator
// ----------------------------------------------------------------------------
package ffea_pkg;

  localparam int unsigned ENTRIES   = 16;
  localparam int unsigned IDX_W     = $clog2(ENTRIES);
  localparam int unsigned CNT_W     = $clog2(ENTRIES + 1);
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned SIZE_W    = 32;
  localparam int unsigned OUT_IDX_W = 4;
  localparam int unsigned ST_W      = 2;

  // kind of a table entry
  typedef enum logic [1:0] {
    KIND_UNUSED = 2'd0,
    KIND_FREE   = 2'd1,
    KIND_FILE   = 2'd2,
    KIND_DIR    = 2'd3
  } kind_e;

  // result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_FULL    = 2'd2,
    ST_ZERO    = 2'd3
  } status_e;

  // input command codes
  typedef enum logic {
    CMD_INIT  = 1'b0,
    CMD_ALLOC = 1'b1
  } cmd_e;

  // configuration register indexes
  typedef enum logic {
    REG_POOL_START = 1'b0,
    REG_POOL_END   = 1'b1
  } reg_e;

  // controller to datapath
  typedef struct packed {
    logic load;         // capture the input beat
    logic init;         // rebuild the table from the pool bounds
    logic scan;         // issue table reads at the scan pointer
    logic ptr_clr;      // restart the scan
    logic take_free;    // latch the fitting free extent
    logic take_unused;  // latch the unused slot
    logic wr_new;       // write the new extent
    logic wr_free;      // shrink or retire the free extent
    logic out_load;     // move the result into the output register
    logic out_ok;       // result carries an extent
  } ffea_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_init;
    logic size_zero;
    logic free_hit;
    logic unused_hit;
    logic scan_end;
  } ffea_stat_t;

endpackage

FILE: rtl/core/ffea_ctrl.sv
// ----------------------------------------------------------------------------
// ffea_ctrl
// sequencer for init, first-fit scan, slot scan and table update
// ----------------------------------------------------------------------------
module ffea_ctrl import ffea_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output status_e    status_o,
  input  ffea_stat_t stat_i,
  output ffea_cmd_t  cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_CHECK   = 8'b0000_0010,
    S_INIT    = 8'b0000_0100,
    S_SCAN_F  = 8'b0000_1000,
    S_SCAN_U  = 8'b0001_0000,
    S_WR_NEW  = 8'b0010_0000,
    S_WR_FREE = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_e;

  state_e  state_q, state_d;
  status_e res_st_q, res_st_d;
  status_e out_st_q, out_st_d;
  logic    out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    res_st_d    = res_st_q;
    out_st_d    = out_st_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.is_init) begin
          state_d = S_INIT;
        end else if (stat_i.size_zero) begin
          res_st_d = ST_ZERO;
          state_d  = S_DONE;
        end else begin
          cmd_o.ptr_clr = 1'b1;
          state_d       = S_SCAN_F;
        end
      end
      S_INIT: begin
        cmd_o.init = 1'b1;
        res_st_d   = ST_OK;
        state_d    = S_DONE;
      end
      S_SCAN_F: begin
        cmd_o.scan = 1'b1;
        if (stat_i.free_hit) begin
          cmd_o.take_free = 1'b1;
          cmd_o.ptr_clr   = 1'b1;
          state_d         = S_SCAN_U;
        end else if (stat_i.scan_end) begin
          res_st_d = ST_NOSPACE;
          state_d  = S_DONE;
        end
      end
      S_SCAN_U: begin
        cmd_o.scan = 1'b1;
        if (stat_i.unused_hit) begin
          cmd_o.take_unused = 1'b1;
          cmd_o.ptr_clr     = 1'b1;
          state_d           = S_WR_NEW;
        end else if (stat_i.scan_end) begin
          res_st_d = ST_FULL;
          state_d  = S_DONE;
        end
      end
      S_WR_NEW: begin
        cmd_o.wr_new = 1'b1;
        res_st_d     = ST_OK;
        state_d      = S_WR_FREE;
      end
      S_WR_FREE: begin
        cmd_o.wr_free = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_ok   = (res_st_q == ST_OK);
          out_st_d       = res_st_q;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_st_q    <= ST_OK;
      out_st_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_st_q    <= res_st_d;
      out_st_q    <= out_st_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_st_q;

endmodule

FILE: rtl/core/ffea_dp.sv
// ----------------------------------------------------------------------------
// ffea_dp
// extent table, pool registers, fit comparator and result registers
// ----------------------------------------------------------------------------
module ffea_dp import ffea_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_index_i,
  input  logic [ADDR_W-1:0]    cfg_data_i,
  input  logic                 cmd_i,
  input  logic [SIZE_W-1:0]    req_size_i,
  input  logic                 entry_type_i,
  input  ffea_cmd_t            cmd_c_i,
  output ffea_stat_t           stat_o,
  output logic [OUT_IDX_W-1:0] entry_index_o,
  output logic [ADDR_W-1:0]    start_addr_o,
  output logic [ADDR_W-1:0]    end_addr_o
);

  // configuration
  logic [ADDR_W-1:0] pool_start_q, pool_end_q;

  // captured beat
  logic              init_q, zero_q, dir_q;
  logic [SIZE_W-1:0] size_q, size_m1_q;

  // table
  kind_e             kind_q [ENTRIES];
  logic [ADDR_W-1:0] first_mem [ENTRIES];
  logic [ADDR_W-1:0] last_mem  [ENTRIES];

  // scan and read stage
  logic [CNT_W-1:0]  ptr_q;
  logic [IDX_W-1:0]  rd_addr;
  logic              issue;
  logic              rd_vld_q;
  logic [IDX_W-1:0]  rd_idx_q;
  kind_e             rd_kind_q;
  logic [ADDR_W-1:0] rd_first_q, rd_last_q;

  // working extent
  logic [IDX_W-1:0]  fr_q, un_q;
  logic [ADDR_W-1:0] fr_first_q, new_last_q;
  logic              exact_q;

  logic [ADDR_W:0]   diff;
  logic              fits, exact;
  logic [ADDR_W-1:0] new_last_c, fr_next_c;

  // table write port
  logic              mem_we_first, mem_we_last;
  logic [IDX_W-1:0]  mem_waddr;
  logic [ADDR_W-1:0] mem_wfirst, mem_wlast;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_start_q <= '0;
      pool_end_q   <= ADDR_W'(65535);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_POOL_START: pool_start_q <= cfg_data_i;
        REG_POOL_END:   pool_end_q   <= cfg_data_i;
        default:        pool_end_q   <= pool_end_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_c_i.load) begin
      init_q    <= (cmd_i == CMD_INIT);
      zero_q    <= (req_size_i == '0);
      dir_q     <= entry_type_i;
      size_q    <= req_size_i;
      size_m1_q <= req_size_i - SIZE_W'(1);
    end
  end

  // inclusive length test: last - first >= size - 1, inverted extents never fit
  assign diff  = {1'b0, rd_last_q} - {1'b0, rd_first_q};
  assign fits  = !diff[ADDR_W] && (diff[ADDR_W-1:0] >= size_m1_q);
  assign exact = !diff[ADDR_W] && (diff[ADDR_W-1:0] == size_m1_q);

  assign new_last_c = fr_first_q + size_m1_q;
  assign fr_next_c  = fr_first_q + size_q;

  assign issue   = cmd_c_i.scan && !cmd_c_i.ptr_clr && (ptr_q != CNT_W'(ENTRIES));
  assign rd_addr = ptr_q[IDX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= issue;
      if (cmd_c_i.ptr_clr) begin
        ptr_q <= '0;
      end else if (issue) begin
        ptr_q <= ptr_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_addr;
    rd_kind_q  <= kind_q[rd_addr];
    rd_first_q <= first_mem[rd_addr];
    rd_last_q  <= last_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        kind_q[i] <= KIND_UNUSED;
      end
    end else if (cmd_c_i.init) begin
      for (int i = 0; i < ENTRIES; i++) begin
        kind_q[i] <= (i == 0) ? KIND_FREE : KIND_UNUSED;
      end
    end else if (cmd_c_i.wr_new) begin
      kind_q[un_q] <= dir_q ? KIND_DIR : KIND_FILE;
    end else if (cmd_c_i.wr_free && exact_q) begin
      kind_q[fr_q] <= KIND_UNUSED;
    end
  end

  always_comb begin
    mem_we_first = 1'b0;
    mem_we_last  = 1'b0;
    mem_waddr    = '0;
    mem_wfirst   = pool_start_q;
    mem_wlast    = pool_end_q;
    if (cmd_c_i.init) begin
      mem_we_first = 1'b1;
      mem_we_last  = 1'b1;
    end else if (cmd_c_i.wr_new) begin
      mem_we_first = 1'b1;
      mem_we_last  = 1'b1;
      mem_waddr    = un_q;
      mem_wfirst   = fr_first_q;
      mem_wlast    = new_last_c;
    end else if (cmd_c_i.wr_free && !exact_q) begin
      mem_we_first = 1'b1;
      mem_waddr    = fr_q;
      mem_wfirst   = fr_next_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we_first) begin
      first_mem[mem_waddr] <= mem_wfirst;
    end
    if (mem_we_last) begin
      last_mem[mem_waddr] <= mem_wlast;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_c_i.init) begin
      un_q       <= '0;
      fr_first_q <= pool_start_q;
      new_last_q <= pool_end_q;
    end else begin
      if (cmd_c_i.take_free) begin
        fr_q       <= rd_idx_q;
        fr_first_q <= rd_first_q;
        exact_q    <= exact;
      end
      if (cmd_c_i.take_unused) begin
        un_q <= rd_idx_q;
      end
      if (cmd_c_i.wr_new) begin
        new_last_q <= new_last_c;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_c_i.out_load) begin
      entry_index_o <= cmd_c_i.out_ok ? OUT_IDX_W'(un_q) : '0;
      start_addr_o  <= cmd_c_i.out_ok ? fr_first_q : '0;
      end_addr_o    <= cmd_c_i.out_ok ? new_last_q : '0;
    end
  end

  assign stat_o.is_init    = init_q;
  assign stat_o.size_zero  = zero_q;
  assign stat_o.free_hit   = rd_vld_q && (rd_kind_q == KIND_FREE) && fits;
  assign stat_o.unused_hit = rd_vld_q && (rd_kind_q == KIND_UNUSED);
  assign stat_o.scan_end   = rd_vld_q && (rd_idx_q == IDX_W'(ENTRIES - 1));

endmodule

FILE: rtl/core/first_fit_extent_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_extent_allocator_unit
// first-fit extent allocator over a small table of extents
// ----------------------------------------------------------------------------
// One command beat in, one result beat out. An init beat rebuilds the table
// as a single free extent pool_start..pool_end and passes through the check,
// init and done states to the result register. An allocate beat reads the
// table one entry per cycle through a registered read port: a first-fit pass
// over the free extents, then a pass for the lowest unused slot, then a write
// of the new extent and a write that shrinks or retires the free extent. A
// miss on free space ends after the first pass and a full table after the
// second. A zero size goes from the check state straight to the done state.
// The sequencer then returns to idle, where the next beat can be taken. The
// next command is taken once the result has moved into the output register,
// even while that result waits for out_ready_i; a result that finds the
// previous one still waiting holds in the done state. Configuration writes
// are always taken.
// ----------------------------------------------------------------------------
module first_fit_extent_allocator_unit import ffea_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_index_i,
  input  logic [ADDR_W-1:0]    cfg_data_i,
  // command channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 cmd_i,
  input  logic [SIZE_W-1:0]    req_size_i,
  input  logic                 entry_type_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [ST_W-1:0]      status_o,
  output logic [OUT_IDX_W-1:0] entry_index_o,
  output logic [ADDR_W-1:0]    start_addr_o,
  output logic [ADDR_W-1:0]    end_addr_o
);

  ffea_cmd_t  ctl_cmd;
  ffea_stat_t dp_stat;
  status_e    res_status;

  // pool registers never stall a write beat
  assign cfg_ready_o = 1'b1;

  // sequencer: accept, check, two scans, table update, result handoff
  ffea_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (res_status),
    .stat_i      (dp_stat),
    .cmd_o       (ctl_cmd)
  );

  // table storage, comparator and result payload
  ffea_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd_i),
    .req_size_i    (req_size_i),
    .entry_type_i  (entry_type_i),
    .cmd_c_i       (ctl_cmd),
    .stat_o        (dp_stat),
    .entry_index_o (entry_index_o),
    .start_addr_o  (start_addr_o),
    .end_addr_o    (end_addr_o)
  );

  assign status_o = res_status;

endmodule
